>>> rtl/core/gprce_pkg.sv
// shared types, constants and hat tables for the gamepad report change-event block
`timescale 1ns / 1ps

package gprce_pkg;

	localparam int NUM_CTRL    = 18;
	localparam int NUM_ANALOG  = 4;
	localparam int NUM_AXES    = 6;
	localparam int ID_W        = 5;
	localparam int VAL_W       = 8;
	localparam int LEN_W       = 7;
	localparam logic [LEN_W-1:0] GOOD_LENGTH = 7'd8;
	localparam logic [VAL_W-1:0] HAT_CENTRE  = 8'd127;

	typedef enum logic [2:0] {
		EVT_ANALOG    = 3'd0,
		EVT_DIGITAL   = 3'd1,
		EVT_PRESS     = 3'd2,
		EVT_RELEASE   = 3'd3,
		EVT_UNHANDLED = 3'd4
	} evt_kind_t;

	typedef enum logic [1:0] {
		CLASS_ANALOG,
		CLASS_DIGITAL,
		CLASS_BUTTON
	} lane_class_t;

	typedef struct packed {
		logic             changed;
		evt_kind_t        kind;
		logic [VAL_W-1:0] value;
	} lane_evt_t;

	typedef lane_evt_t [NUM_CTRL-1:0] lane_evt_vec_t;

	function automatic logic [VAL_W-1:0] hat_to_x(input logic [3:0] code);
		logic [VAL_W-1:0] r;
		unique case (code)
			4'd1, 4'd2, 4'd3: r = 8'd255;
			4'd5, 4'd6, 4'd7: r = 8'd0;
			default:          r = HAT_CENTRE;
		endcase
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] hat_to_y(input logic [3:0] code);
		logic [VAL_W-1:0] r;
		unique case (code)
			4'd0, 4'd1, 4'd7: r = 8'd0;
			4'd3, 4'd4, 4'd5: r = 8'd255;
			default:          r = HAT_CENTRE;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/gprce_lane.sv
// one control lane: holds the previous value and flags a change
`timescale 1ns / 1ps

module gprce_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              update,
	input  gprce_pkg::lane_class_t            lane_class,
	input  logic [gprce_pkg::VAL_W-1:0]       cur,
	output gprce_pkg::lane_evt_t              evt
);

	logic [gprce_pkg::VAL_W-1:0] prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (update) begin
			prev_q <= cur;
		end
	end

	always_comb begin
		evt.changed = (cur != prev_q);
		unique case (lane_class)
			gprce_pkg::CLASS_ANALOG: begin
				evt.kind  = gprce_pkg::EVT_ANALOG;
				evt.value = cur;
			end
			gprce_pkg::CLASS_DIGITAL: begin
				evt.kind  = gprce_pkg::EVT_DIGITAL;
				evt.value = cur;
			end
			default: begin
				evt.kind  = cur[0] ? gprce_pkg::EVT_PRESS : gprce_pkg::EVT_RELEASE;
				evt.value = '0;
			end
		endcase
	end

endmodule

>>> rtl/core/gprce_merge.sv
// merging stage: drains changed lanes by id, one event per cycle if unstalled
`timescale 1ns / 1ps

module gprce_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic                              unhandled,
	input  logic [gprce_pkg::LEN_W-1:0]       length,
	input  gprce_pkg::lane_evt_vec_t          evts,
	output logic                              busy,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,  // control_id, event_value
	output logic [2:0]                        m_tuser,  // event_kind
	output logic                              m_tlast
);

	logic [gprce_pkg::NUM_CTRL-1:0] pend_q;
	logic                           unh_pend_q;
	logic [gprce_pkg::LEN_W-1:0]    unh_len_q;
	gprce_pkg::lane_evt_vec_t       evt_q;

	logic                           out_valid_q;
	gprce_pkg::evt_kind_t           out_kind_q;
	logic [gprce_pkg::ID_W-1:0]     out_id_q;
	logic [gprce_pkg::VAL_W-1:0]    out_val_q;
	logic                           out_last_q;

	logic [gprce_pkg::NUM_CTRL-1:0] changed_mask;
	logic [gprce_pkg::NUM_CTRL-1:0] sel_bit;
	logic [gprce_pkg::ID_W-1:0]     sel;
	logic                           advance;

	always_comb begin
		for (int i = 0; i < gprce_pkg::NUM_CTRL; i++) begin
			changed_mask[i] = evts[i].changed;
		end
	end

	// lowest pending id wins
	always_comb begin
		sel = '0;
		for (int i = gprce_pkg::NUM_CTRL - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = gprce_pkg::ID_W'(i);
			end
		end
		sel_bit = gprce_pkg::NUM_CTRL'(1) << sel;
	end

	assign busy    = (pend_q != '0) || unh_pend_q;
	assign advance = busy && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			unh_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q     <= unhandled ? '0 : changed_mask;
				unh_pend_q <= unhandled;
			end else if (advance) begin
				if (unh_pend_q) begin
					unh_pend_q <= 1'b0;
				end else begin
					pend_q <= pend_q & ~sel_bit;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			evt_q     <= evts;
			unh_len_q <= length;
		end
		if (advance) begin
			if (unh_pend_q) begin
				out_kind_q <= gprce_pkg::EVT_UNHANDLED;
				out_id_q   <= '0;
				out_val_q  <= gprce_pkg::VAL_W'(unh_len_q);
				out_last_q <= 1'b1;
			end else begin
				out_kind_q <= evt_q[sel].kind;
				out_id_q   <= sel;
				out_val_q  <= evt_q[sel].value;
				out_last_q <= ((pend_q & ~sel_bit) == '0);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {3'b000, out_val_q, out_id_q};
	assign m_tlast  = out_last_q;

endmodule

>>> rtl/core/gamepad_report_change_events.sv
// top level of the gamepad report change-event block
`timescale 1ns / 1ps
//
// takes one gamepad report per request on the s_ channel: report length and
// six payload bytes. eighteen lanes compare each decoded control with the
// value kept from the previous report; the merging stage then sends one
// event per changed control, lowest id first, on the m_ channel, with tlast
// on the final event of the report
// a report whose length is not 8 gives a single unhandled event and leaves
// the stored controls alone; a report with no change gives no event at all
// the first event passes the report register, the pending mask and the output
// register; the merging stage then sends one event per cycle while not stalled,
// 0 to 18 events per report; the next report is taken once the last event of
// this one sits in the output register
// a stalled receiver holds the output register and pauses the draining
// reset clears the stored axes to 0 and the buttons to released, and empties
// the pipeline
//
module gamepad_report_change_events (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // report_length, left_x_byte, left_y_byte, right_x_byte,
	                              // right_y_byte, hat_buttons_byte, more_buttons_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // control_id, event_value
	output logic [2:0]  m_tuser,  // event_kind
	output logic        m_tlast
);

	logic                            rep_valid_s1;
	logic [54:0]                     rep_s1;
	logic                            merge_busy;
	logic                            len_ok;
	logic [gprce_pkg::LEN_W-1:0]     len;
	logic [7:0]                      hat_byte;
	logic [7:0]                      more_byte;
	logic [gprce_pkg::VAL_W-1:0]     cur [gprce_pkg::NUM_CTRL];
	gprce_pkg::lane_evt_vec_t        evts;

	assign s_tready = !rep_valid_s1 && !merge_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_valid_s1 <= 1'b0;
		end else begin
			rep_valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rep_s1 <= s_tdata[54:0];
		end
	end

	assign len       = rep_s1[6:0];
	assign len_ok    = (len == gprce_pkg::GOOD_LENGTH);
	assign hat_byte  = rep_s1[46:39];
	assign more_byte = rep_s1[54:47];

	// control values in id order
	always_comb begin
		cur[0]  = rep_s1[14:7];
		cur[1]  = rep_s1[22:15];
		cur[2]  = rep_s1[30:23];
		cur[3]  = rep_s1[38:31];
		cur[4]  = gprce_pkg::hat_to_x(hat_byte[3:0]);
		cur[5]  = gprce_pkg::hat_to_y(hat_byte[3:0]);
		cur[6]  = {7'd0, hat_byte[4]};
		cur[7]  = {7'd0, hat_byte[5]};
		cur[8]  = {7'd0, hat_byte[6]};
		cur[9]  = {7'd0, hat_byte[7]};
		cur[10] = {7'd0, more_byte[7]};
		cur[11] = {7'd0, more_byte[6]};
		cur[12] = {7'd0, more_byte[5]};
		cur[13] = {7'd0, more_byte[4]};
		cur[14] = {7'd0, more_byte[0]};
		cur[15] = {7'd0, more_byte[1]};
		cur[16] = {7'd0, more_byte[2]};
		cur[17] = {7'd0, more_byte[3]};
	end

	for (genvar g = 0; g < gprce_pkg::NUM_CTRL; g++) begin : g_lane
		localparam gprce_pkg::lane_class_t LCLASS =
			(g < gprce_pkg::NUM_ANALOG) ? gprce_pkg::CLASS_ANALOG :
			(g < gprce_pkg::NUM_AXES)   ? gprce_pkg::CLASS_DIGITAL :
			                              gprce_pkg::CLASS_BUTTON;
		gprce_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.update     (rep_valid_s1 && len_ok),
			.lane_class (LCLASS),
			.cur        (cur[g]),
			.evt        (evts[g])
		);
	end

	gprce_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (rep_valid_s1),
		.unhandled (!len_ok),
		.length    (len),
		.evts      (evts),
		.busy      (merge_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
